[rtl/core/cds_pkg.sv]
package cds_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int DIV_BITS  = 2 * FRAC_BITS + 2;

   localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic signed [WORD_BITS-1:0] ONE  = WORD_BITS'(64'd1 << FRAC_BITS);

   localparam longint MIN_SMOOTH_RAW = ((64'sd1 <<< FRAC_BITS) + 5000) / 10000;
   localparam logic [WORD_BITS-1:0] MIN_SMOOTH =
      WORD_BITS'((MIN_SMOOTH_RAW > 0) ? MIN_SMOOTH_RAW : 1);
   localparam logic signed [WORD_BITS-1:0] C_048 =
      WORD_BITS'(((64'd48 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [WORD_BITS-1:0] C_0235 =
      WORD_BITS'(((64'd235 << FRAC_BITS) + 64'd500) / 64'd1000);

   localparam int CSR_SMOOTH_TIME = 0;
   localparam int CSR_MAX_SPEED   = 1;

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   function automatic word_type sat_wide(input logic signed [WORD_BITS+1:0] v);
      word_type r;
      if (v > $signed({{2{1'b0}}, WMAX})) begin
         r = WMAX;
      end else if (v < $signed({{2{1'b1}}, WMIN})) begin
         r = WMIN;
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b,
                                        input logic sub);
      logic signed [WORD_BITS+1:0] s;
      if (sub) begin
         s = {{2{a[WORD_BITS-1]}}, a} - {{2{b[WORD_BITS-1]}}, b};
      end else begin
         s = {{2{a[WORD_BITS-1]}}, a} + {{2{b[WORD_BITS-1]}}, b};
      end
      return sat_wide(s);
   endfunction

endpackage

[rtl/core/critically_damped_smoother.sv]
// A transaction passes from req to rsp valid through two bit-serial divisions,
// 11 products on one shared multiplier and one finishing state.
// One request is handled at a time; req_stall is high while busy.
// A result waiting on a stalled rsp blocks acceptance of the next request.
// Reset (synchronous, active high): velocity 0, smooth_time 1.0, max_speed max.
module critically_damped_smoother (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_current_value,
   input  logic signed [31:0] req_target_value,
   input  logic [20:0]        req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_smoothed_value,
   output logic signed [31:0] rsp_new_velocity,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [30:0]        csr_data
);
   localparam int W = cds_pkg::WORD_BITS;
   localparam int F = cds_pkg::FRAC_BITS;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_OMEGA = 5'd1;
   localparam logic [4:0] S_X     = 5'd2;
   localparam logic [4:0] S_X2    = 5'd3;
   localparam logic [4:0] S_X3    = 5'd4;
   localparam logic [4:0] S_T2    = 5'd5;
   localparam logic [4:0] S_T3    = 5'd6;
   localparam logic [4:0] S_EXP   = 5'd7;
   localparam logic [4:0] S_MAXC  = 5'd8;
   localparam logic [4:0] S_OC    = 5'd9;
   localparam logic [4:0] S_TMP   = 5'd10;
   localparam logic [4:0] S_OT    = 5'd11;
   localparam logic [4:0] S_VEL   = 5'd12;
   localparam logic [4:0] S_RES   = 5'd13;
   localparam logic [4:0] S_FIN   = 5'd14;

   logic [4:0] state_ff, state_in;
   logic       wait_ff, wait_in;
   logic [24:0] smooth_ff;
   logic [30:0] speed_ff;
   cds_pkg::word_type vel_ff, vel_in;
   cds_pkg::word_type cur_ff, cur_in, org_ff, org_in, dt_ff, dt_in, st_ff, st_in;
   cds_pkg::word_type om_ff, om_in, x_ff, x_in, x2_ff, x2_in, den_ff, den_in;
   cds_pkg::word_type ex_ff, ex_in, chg_ff, chg_in, tmp_ff, tmp_in, res_ff, res_in;
   cds_pkg::word_type nvel_ff, nvel_in;
   logic       ov_ff, ov_in;
   cds_pkg::word_type ma, mb, mp;
   cds_pkg::div_ctl_type dctl;
   logic [cds_pkg::DIV_BITS-1:0] dnum;
   logic [W-1:0] dden;
   logic       ddone;
   cds_pkg::word_type dquo, maxc, nmaxc, sdiff;
   logic       pin;

   cds_mul u_mul (.clock(clock), .a(ma), .b(mb), .p_ff(mp));
   cds_div u_div (.clock(clock), .reset(reset), .ctl(dctl), .num(dnum),
                  .den(dden), .done_ff(ddone), .quo(dquo));

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid && rsp_stall);

   always_comb begin
      state_in = state_ff; wait_in = 1'b0;
      vel_in = vel_ff; cur_in = cur_ff; org_in = org_ff; dt_in = dt_ff; st_in = st_ff;
      om_in = om_ff; x_in = x_ff; x2_in = x2_ff; den_in = den_ff; ex_in = ex_ff;
      chg_in = chg_ff; tmp_in = tmp_ff; res_in = res_ff; nvel_in = nvel_ff; ov_in = ov_ff;
      ma = '0; mb = '0;
      dctl = '0; dnum = '0; dden = st_ff;
      maxc = mp; nmaxc = cds_pkg::sat_add('0, mp, 1'b1);
      sdiff = '0; pin = 1'b0;
      if (rsp_valid && !rsp_stall) ov_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cur_in = req_current_value;
               org_in = req_target_value;
               dt_in  = W'(req_time_step);
               st_in  = (W'(smooth_ff) < cds_pkg::MIN_SMOOTH) ? cds_pkg::MIN_SMOOTH
                        : W'(smooth_ff);
               state_in = S_OMEGA;
               wait_in = 1'b1;
            end
         end
         S_OMEGA: begin
            dnum = cds_pkg::DIV_BITS'(1) << (2 * F + 1);
            dden = st_ff;
            dctl.start = wait_ff;
            if (ddone) begin
               om_in = dquo;
               state_in = S_X;
               wait_in = 1'b1;
            end
         end
         S_X: begin
            ma = om_ff; mb = dt_ff;
            if (!wait_ff) begin
               x_in = mp; state_in = S_X2; wait_in = 1'b1;
            end
         end
         S_X2: begin
            ma = x_ff; mb = x_ff;
            if (!wait_ff) begin
               x2_in = mp; state_in = S_X3; wait_in = 1'b1;
            end
         end
         S_X3: begin
            ma = x2_ff; mb = x_ff;
            if (!wait_ff) begin
               tmp_in = mp; state_in = S_T2; wait_in = 1'b1;
               den_in = cds_pkg::sat_add(cds_pkg::ONE, x_ff, 1'b0);
            end
         end
         S_T2: begin
            ma = cds_pkg::C_048; mb = x2_ff;
            if (!wait_ff) begin
               den_in = cds_pkg::sat_add(den_ff, mp, 1'b0);
               state_in = S_T3; wait_in = 1'b1;
            end
         end
         S_T3: begin
            ma = cds_pkg::C_0235; mb = tmp_ff;
            if (!wait_ff) begin
               den_in = cds_pkg::sat_add(den_ff, mp, 1'b0);
               state_in = S_EXP; wait_in = 1'b1;
            end
         end
         S_EXP: begin
            dnum = cds_pkg::DIV_BITS'(1) << (2 * F);
            dden = den_ff;
            dctl.start = wait_ff;
            if (ddone) begin
               ex_in = dquo; state_in = S_MAXC; wait_in = 1'b1;
            end
         end
         S_MAXC: begin
            ma = W'(speed_ff); mb = st_ff;
            if (!wait_ff) begin
               sdiff = cds_pkg::sat_add(cur_ff, org_ff, 1'b1);
               if (sdiff > maxc) sdiff = maxc;
               if (sdiff < nmaxc) sdiff = nmaxc;
               chg_in = sdiff;
               res_in = cds_pkg::sat_add(cur_ff, sdiff, 1'b1);
               state_in = S_OC; wait_in = 1'b1;
            end
         end
         S_OC: begin
            ma = om_ff; mb = chg_ff;
            if (!wait_ff) begin
               tmp_in = cds_pkg::sat_add(vel_ff, mp, 1'b0);
               state_in = S_TMP; wait_in = 1'b1;
            end
         end
         S_TMP: begin
            ma = tmp_ff; mb = dt_ff;
            if (!wait_ff) begin
               tmp_in = mp; state_in = S_OT; wait_in = 1'b1;
            end
         end
         S_OT: begin
            ma = om_ff; mb = tmp_ff;
            if (!wait_ff) begin
               nvel_in = cds_pkg::sat_add(vel_ff, mp, 1'b1);
               state_in = S_VEL; wait_in = 1'b1;
            end
         end
         S_VEL: begin
            ma = nvel_ff; mb = ex_ff;
            if (!wait_ff) begin
               nvel_in = mp; state_in = S_RES; wait_in = 1'b1;
            end
         end
         S_RES: begin
            ma = cds_pkg::sat_add(chg_ff, tmp_ff, 1'b0); mb = ex_ff;
            if (!wait_ff) begin
               res_in = cds_pkg::sat_add(res_ff, mp, 1'b0);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            pin = ((org_ff > cur_ff) == (res_ff > org_ff));
            if (pin) begin
               res_in = org_ff; nvel_in = '0; vel_in = '0;
            end else begin
               vel_in = nvel_ff;
            end
            ov_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; org_ff <= org_in; dt_ff <= dt_in; st_ff <= st_in;
      om_ff <= om_in; x_ff <= x_in; x2_ff <= x2_in; den_ff <= den_in; ex_ff <= ex_in;
      chg_ff <= chg_in; tmp_ff <= tmp_in; res_ff <= res_in; nvel_ff <= nvel_in;
      if (reset) begin
         state_ff <= S_IDLE; wait_ff <= 1'b0; vel_ff <= '0; ov_ff <= 1'b0;
         smooth_ff <= 25'd65536; speed_ff <= 31'h7FFFFFFF;
      end else begin
         state_ff <= state_in; wait_ff <= wait_in; vel_ff <= vel_in;
         ov_ff <= ov_in;
         if (csr_write) begin
            if (csr_index == 1'(cds_pkg::CSR_SMOOTH_TIME)) smooth_ff <= csr_data[24:0];
            else speed_ff <= csr_data;
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_smoothed_value = res_ff;
   assign rsp_new_velocity = vel_ff;

`ifndef SYNTHESIS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accept while busy");
   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |=> rsp_valid) else $error("no result after finish");
   a_vel_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_new_velocity == vel_ff)) else $error("velocity mismatch");
`endif
endmodule

[rtl/core/cds_mul.sv]
module cds_mul (
   input  logic                                  clock,
   input  logic signed [cds_pkg::WORD_BITS-1:0] a,
   input  logic signed [cds_pkg::WORD_BITS-1:0] b,
   output logic signed [cds_pkg::WORD_BITS-1:0] p_ff
);
   localparam int W = cds_pkg::WORD_BITS;
   localparam int F = cds_pkg::FRAC_BITS;

   logic [W:0] ua;
   logic [W:0] ub;
   logic [2*W+1:0] prod;
   logic [2*W+1:0] q;
   logic neg;
   logic signed [W-1:0] p_in;

   always_comb begin
      neg  = a[W-1] ^ b[W-1];
      ua   = a[W-1] ? ((W+1)'(0) - {a[W-1], a}) : {1'b0, a};
      ub   = b[W-1] ? ((W+1)'(0) - {b[W-1], b}) : {1'b0, b};
      prod = ua * ub;
      q    = (prod + ((2*W+2)'(1) << (F - 1))) >> F;
      if (!neg) begin
         p_in = (q > (2*W+2)'(cds_pkg::WMAX)) ? cds_pkg::WMAX : q[W-1:0];
      end else begin
         p_in = (q > (2*W+2)'(cds_pkg::WMAX) + (2*W+2)'(1)) ? cds_pkg::WMIN
                : W'((W)'(0) - q[W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end
endmodule

[rtl/core/cds_div.sv]
module cds_div (
   input  logic                                clock,
   input  logic                                reset,
   input  cds_pkg::div_ctl_type                ctl,
   input  logic [cds_pkg::DIV_BITS-1:0]        num,
   input  logic [cds_pkg::WORD_BITS-1:0]       den,
   output logic                                done_ff,
   output logic signed [cds_pkg::WORD_BITS-1:0] quo
);
   localparam int N = cds_pkg::DIV_BITS + cds_pkg::WORD_BITS;
   localparam int W = cds_pkg::WORD_BITS;
   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  q_ff, q_in;
   logic [W:0]    r_ff, r_in;
   logic [W-1:0]  d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_in;
   logic [W:0]    trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      trial = '0;
      if (ctl.start) begin
         q_in   = N'(num) + N'(den >> 1);
         r_in   = '0;
         d_in   = den;
         cnt_in = CW'(N);
         run_in = 1'b1;
      end else if (run_ff) begin
         trial = {r_ff[W-1:0], q_ff[N-1]};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[N-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (q_ff > N'(cds_pkg::WMAX)) quo = cds_pkg::WMAX;
      else quo = q_ff[W-1:0];
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

`ifndef SYNTHESIS
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff)) else $error("div done without run");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !run_ff) else $error("div restarted while busy");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff) else $error("div still running at done");
`endif
endmodule

[bench/critically_damped_smoother_tb.sv]
`timescale 1ns / 1ps

module critically_damped_smoother_tb;

   localparam longint W_MAX = 64'sd2147483647;
   localparam longint W_MIN = -64'sd2147483648;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 600;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      cds_pkg::word_type value;
      cds_pkg::word_type velocity;
   } smooth_out_type;

   typedef struct {
      cds_pkg::word_type cur;
      cds_pkg::word_type tgt;
      logic [20:0]       dt;
      bit                known;
      cds_pkg::word_type value;
      cds_pkg::word_type velocity;
   } stim_row_type;

   logic               clock = 0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   cds_pkg::word_type  req_current_value;
   cds_pkg::word_type  req_target_value;
   logic [20:0]        req_time_step;
   logic               rsp_valid;
   logic               rsp_stall;
   cds_pkg::word_type  rsp_smoothed_value;
   cds_pkg::word_type  rsp_new_velocity;
   logic               csr_write;
   logic [0:0]         csr_index;
   logic [30:0]        csr_data;

   smooth_out_type     pending_q[$];
   longint             model_velocity;
   longint             model_smooth_time;
   longint             model_max_speed;
   cds_pkg::word_type  last_value;
   idle_mode_type      idle_mode;
   int                 errors;
   int                 quiet_cycles;
   bit                 hold_go;
   int                 hold_left;

   int n_items[8] = '{140, 100, 100, 100, 100, 100, 80, 100};
   longint smooth_set[8] = '{65536, 0, 16777216, 7, 8, 0, 16384, 1};
   longint speed_set[8] = '{2147483647, 2147483647, 0, 655360, 1, 0, 2147483647,
                            2147483647};
   idle_mode_type mode_set[8] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                  IDLE_NONE, IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER};

   critically_damped_smoother uut (.*);

   always #4 clock = ~clock;

   function automatic longint clamp_word(input longint v);
      if (v > W_MAX) return W_MAX;
      if (v < W_MIN) return W_MIN;
      return v;
   endfunction

   function automatic longint fx_mul(input longint a, input longint b);
      bit neg;
      longint unsigned ua, ub, q;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? longint'(-a) : a;
      ub = (b < 0) ? longint'(-b) : b;
      q = (ua * ub + (64'd1 << (cds_pkg::FRAC_BITS - 1))) >> cds_pkg::FRAC_BITS;
      if (!neg) return (q > 64'd2147483647) ? W_MAX : longint'(q);
      return (q > 64'd2147483648) ? W_MIN : -longint'(q);
   endfunction

   function automatic longint fx_div(input longint num, input longint den);
      return clamp_word((num + den / 2) / den);
   endfunction

   function automatic smooth_out_type smooth_step(input cds_pkg::word_type cur_in,
                                                  input cds_pkg::word_type tgt_in,
                                                  input logic [20:0] dt_in);
      longint cur, orig, dt, st, omega, x, x2, x3, den, ex;
      longint change, maxc, tgt, tmp, vel, res;
      smooth_out_type o;
      cur = cur_in;
      orig = tgt_in;
      dt = dt_in;
      st = (model_smooth_time < cds_pkg::MIN_SMOOTH) ? longint'(cds_pkg::MIN_SMOOTH)
           : model_smooth_time;
      omega = fx_div(64'sd1 << (2 * cds_pkg::FRAC_BITS + 1), st);
      x = fx_mul(omega, dt);
      x2 = fx_mul(x, x);
      x3 = fx_mul(x2, x);
      den = clamp_word(longint'(cds_pkg::ONE) + x + fx_mul(cds_pkg::C_048, x2) +
                       fx_mul(cds_pkg::C_0235, x3));
      ex = fx_div(64'sd1 << (2 * cds_pkg::FRAC_BITS), den);
      change = clamp_word(cur - orig);
      maxc = fx_mul(model_max_speed, st);
      if (change > maxc) change = maxc;
      if (change < -maxc) change = -maxc;
      tgt = clamp_word(cur - change);
      tmp = fx_mul(clamp_word(model_velocity + fx_mul(omega, change)), dt);
      vel = fx_mul(clamp_word(model_velocity - fx_mul(omega, tmp)), ex);
      res = clamp_word(tgt + fx_mul(clamp_word(change + tmp), ex));
      if ((orig - cur > 0) == (res > orig)) begin
         res = orig;
         vel = 0;
      end
      model_velocity = vel;
      o.value = cds_pkg::word_type'(res);
      o.velocity = cds_pkg::word_type'(vel);
      return o;
   endfunction

   function automatic bit sender_idles();
      if (idle_mode == IDLE_SENDER) return $urandom_range(99) < 81;
      if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 36;
      return 0;
   endfunction

   // receiver side: random stall plus a single long hold-off
   always @(posedge clock) begin
      if (hold_go) begin
         hold_go = 0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (idle_mode == IDLE_RECEIVER) begin
         rsp_stall <= $urandom_range(99) < 81;
      end else if (idle_mode == IDLE_BOTH) begin
         rsp_stall <= $urandom_range(99) < 36;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      smooth_out_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            $error("unexpected transaction: value %0d velocity %0d",
                   rsp_smoothed_value, rsp_new_velocity);
            errors++;
         end else begin
            e = pending_q.pop_front();
            if (rsp_smoothed_value !== e.value) begin
               $error("smoothed_value: expected %0d, got %0d", e.value, rsp_smoothed_value);
               errors++;
            end
            if (rsp_new_velocity !== e.velocity) begin
               $error("new_velocity: expected %0d, got %0d", e.velocity, rsp_new_velocity);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_item(input stim_row_type r);
      smooth_out_type p;
      req_valid <= 1'b1;
      req_current_value <= r.cur;
      req_target_value <= r.tgt;
      req_time_step <= r.dt;
      do @(posedge clock); while (req_stall);
      p = smooth_step(r.cur, r.tgt, r.dt);
      last_value = p.value;
      if (r.known) begin
         p.value = r.value;
         p.velocity = r.velocity;
      end
      pending_q.push_back(p);
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(input int idx, input longint value);
      csr_write <= 1'b1;
      csr_index <= 1'(idx);
      csr_data <= 31'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      if (idx == cds_pkg::CSR_SMOOTH_TIME) model_smooth_time = value & 64'h1FFFFFF;
      else model_max_speed = value & 64'h7FFFFFFF;
   endtask

   function automatic stim_row_type random_row();
      stim_row_type r;
      int pick;
      r.known = 0;
      r.value = 0;
      r.velocity = 0;
      pick = $urandom_range(9);
      if (pick < 5) begin
         // follow the trajectory, usually toward a nearby target
         r.cur = last_value;
         r.tgt = cds_pkg::word_type'(clamp_word(longint'(last_value) +
                 $signed($urandom_range(2000000)) - 1000000));
         if ($urandom_range(9) == 0) r.tgt = $urandom;
      end else if (pick < 8) begin
         r.cur = $urandom;
         r.tgt = $urandom;
      end else begin
         r.cur = $signed($urandom_range(200000)) - 100000;
         r.tgt = r.cur + $signed($urandom_range(20)) - 10;
      end
      if ($urandom_range(3) == 0) r.dt = 21'($urandom_range(1048576, 1));
      else r.dt = 21'($urandom_range(8192, 1));
      return r;
   endfunction

   stim_row_type directed[$] = '{
      '{32'sd0, 32'sd0, 21'd1, 1'b1, 32'sd0, 32'sd0},
      '{cds_pkg::WMIN, cds_pkg::WMIN, 21'd1048576, 1'b1, cds_pkg::WMIN, 32'sd0},
      '{cds_pkg::WMAX, cds_pkg::WMAX, 21'd1048575, 1'b1, cds_pkg::WMAX, 32'sd0},
      '{32'sd0, 32'sd65536, 21'd1092, 1'b0, 32'sd0, 32'sd0},
      '{32'sd0, 32'sd65536, 21'd1092, 1'b0, 32'sd0, 32'sd0},
      '{32'sd4000, 32'sd65536, 21'd1092, 1'b0, 32'sd0, 32'sd0},
      '{cds_pkg::WMIN, cds_pkg::WMAX, 21'd1, 1'b0, 32'sd0, 32'sd0},
      '{cds_pkg::WMAX, cds_pkg::WMIN, 21'd1048576, 1'b0, 32'sd0, 32'sd0},
      '{cds_pkg::WMIN, cds_pkg::WMAX, 21'd1048575, 1'b0, 32'sd0, 32'sd0},
      '{32'sd0, 32'sd100, 21'd1048576, 1'b0, 32'sd0, 32'sd0},
      '{32'sd100, 32'sd0, 21'd1048576, 1'b0, 32'sd0, 32'sd0},
      '{32'sd100, 32'sd100, 21'd65536, 1'b0, 32'sd0, 32'sd0},
      '{-32'sd65536, 32'sd65536, 21'd32768, 1'b0, 32'sd0, 32'sd0},
      '{32'sd65536, -32'sd65536, 21'd1, 1'b0, 32'sd0, 32'sd0},
      '{32'sd12345, 32'sd12346, 21'd2, 1'b0, 32'sd0, 32'sd0},
      '{-32'sd1, 32'sd0, 21'd699050, 1'b0, 32'sd0, 32'sd0},
      '{32'sd1, -32'sd1, 21'd349525, 1'b0, 32'sd0, 32'sd0}
   };

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_current_value = 0;
      req_target_value = 0;
      req_time_step = 21'd1;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = 1'b0;
      csr_data = 31'd0;
      errors = 0;
      quiet_cycles = 0;
      hold_go = 0;
      hold_left = 0;
      idle_mode = IDLE_NONE;
      model_velocity = 0;
      model_smooth_time = 65536;
      model_max_speed = 2147483647;
      last_value = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i]);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 5) begin
            smooth_set[ph] = $urandom_range(16777216);
            speed_set[ph] = $urandom_range(32'h7FFFFFFF);
         end
         write_csr(cds_pkg::CSR_SMOOTH_TIME, smooth_set[ph]);
         write_csr(cds_pkg::CSR_MAX_SPEED, speed_set[ph]);
         idle_mode = mode_set[ph];
         if (ph == 4) hold_go = 1;
         for (int k = 0; k < n_items[ph]; k++) send_item(random_row());
         drain();
      end

      idle_mode = IDLE_NONE;
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
